// File: rtl/xorshift_table_key_generator_macros.svh
// assertion macros for the xorshift table key generator
`ifndef XORSHIFT_TABLE_KEY_GENERATOR_MACROS_SVH
`define XORSHIFT_TABLE_KEY_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define XTKG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xtkg same-cycle check failed");
// next-cycle implication, checked out of reset
`define XTKG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xtkg next-cycle check failed");
`else
`define XTKG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define XTKG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/xtkg_pkg.sv
// shared types, constants and pick table of the xorshift table key generator
package xtkg_pkg;

    localparam logic [31:0] WORD2_START = 32'h82A28C10;
    localparam int          SHL_OLDEST  = 11;
    localparam int          SHR_T       = 8;
    localparam int          SHR_NEWEST  = 19;
    localparam int          SEED_W      = 32;
    localparam int          KEY_W       = 32;
    localparam int          IDX_W       = 2;
    localparam int          IN_DATA_W   = 4 * SEED_W;
    localparam int          OUT_DATA_W  = 40;
    localparam logic [1:0]  LAST_BYTE   = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic             seed_load;
        logic             step;
        logic             pick;
        logic             first_byte;
        logic             last_byte;
        logic             word2;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] out_index;
    } xtkg_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic stall;
    } xtkg_stat_t;

    // one xorshift128 draw: next newest word
    function automatic logic [31:0] gen_next(input logic [31:0] oldest,
                                             input logic [31:0] newest);
        logic [31:0] t;
        t = oldest ^ (oldest << SHL_OLDEST);
        return newest ^ (newest >> SHR_NEWEST) ^ t ^ (t >> SHR_T);
    endfunction

    // fixed table of 64 words
    function automatic logic [31:0] pick_word(input logic [5:0] idx);
        logic [31:0] w;
        unique case (idx)
            6'd0:  w = 32'h39B399D2;  6'd1:  w = 32'hFAE40B38;
            6'd2:  w = 32'h851BC213;  6'd3:  w = 32'h8CB4E3D9;
            6'd4:  w = 32'h7ED1C46A;  6'd5:  w = 32'hE8050462;
            6'd6:  w = 32'hD8D24F76;  6'd7:  w = 32'hB52886FC;
            6'd8:  w = 32'h67890BF0;  6'd9:  w = 32'hF5329CB0;
            6'd10: w = 32'hD597FB28;  6'd11: w = 32'h2B8EE0EA;
            6'd12: w = 32'h47574C51;  6'd13: w = 32'h0F7569D9;
            6'd14: w = 32'hCF1163AE;  6'd15: w = 32'hE4A153BF;
            6'd16: w = 32'hD1FAE468;  6'd17: w = 32'hD4C64738;
            6'd18: w = 32'h360106F5;  6'd19: w = 32'hDD7EB113;
            6'd20: w = 32'hC296F3E2;  6'd21: w = 32'h2C58F258;
            6'd22: w = 32'h79B554E1;  6'd23: w = 32'h85DF9D06;
            6'd24: w = 32'hAA307330;  6'd25: w = 32'h01410F69;
            6'd26: w = 32'hB2F2C573;  6'd27: w = 32'h82B93EB1;
            6'd28: w = 32'hF351A11C;  6'd29: w = 32'h63098693;
            6'd30: w = 32'h885B5DA5;  6'd31: w = 32'h8872A8ED;
            6'd32: w = 32'hACD9CB13;  6'd33: w = 32'hED7FBCAD;
            6'd34: w = 32'hE6A41EC2;  6'd35: w = 32'h5F44E79F;
            6'd36: w = 32'h8346F5B5;  6'd37: w = 32'h389FE6ED;
            6'd38: w = 32'h507124B5;  6'd39: w = 32'hE9B23EAA;
            6'd40: w = 32'h577113F0;  6'd41: w = 32'hA95ED917;
            6'd42: w = 32'h2F62D158;  6'd43: w = 32'h47843F86;
            6'd44: w = 32'hC65637D0;  6'd45: w = 32'h2F272052;
            6'd46: w = 32'hBA4A4CC4;  6'd47: w = 32'hB5F146F6;
            6'd48: w = 32'h501B87A7;  6'd49: w = 32'h51FC3A93;
            6'd50: w = 32'h6EDE3F02;  6'd51: w = 32'h3D265728;
            6'd52: w = 32'h9B809440;  6'd53: w = 32'h75B89229;
            6'd54: w = 32'hF6A280CC;  6'd55: w = 32'h8537FA68;
            6'd56: w = 32'h5B5ED19A;  6'd57: w = 32'h6FC05BB6;
            6'd58: w = 32'hF4EF5261;  6'd59: w = 32'hAA1B7D4F;
            6'd60: w = 32'hFCB26110;  6'd61: w = 32'h00AD3D74;
            6'd62: w = 32'hC0E73A4B;  6'd63: w = 32'hF132E7C7;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/xtkg_ctrl.sv
// controller: sequences draws, bytes and key words for one input word
`include "xorshift_table_key_generator_macros.svh"
module xtkg_ctrl #(
    parameter int KEY_WORDS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_cmd,
    input  xtkg_pkg::xtkg_stat_t stat,
    output xtkg_pkg::xtkg_cmd_t  cmd
);
    import xtkg_pkg::*;

    localparam int WCW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t           state_reg;
    logic [1:0]       byte_cnt_reg;
    logic             phase_reg;
    logic [WCW-1:0]   word_cnt_reg;
    logic [WCW+1:0]   word_ext;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign word_ext = {2'b00, word_cnt_reg};

    // command decode
    always_comb begin
        cmd            = '0;
        cmd.seed_load  = accept && s_cmd;
        cmd.step       = (state_reg == ST_RUN) && !stat.stall;
        cmd.pick       = phase_reg;
        cmd.first_byte = (byte_cnt_reg == 2'd0);
        cmd.last_byte  = (byte_cnt_reg == LAST_BYTE);
        cmd.word2      = (word_ext == (WCW+2)'(2));
        cmd.out_index  = word_ext[1:0];
        cmd.out_last   = (word_cnt_reg == WCW'(KEY_WORDS - 1));
        cmd.out_load   = cmd.step && phase_reg && cmd.last_byte;
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            byte_cnt_reg <= '0;
            phase_reg    <= 1'b0;
            word_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg    <= ST_RUN;
                        byte_cnt_reg <= '0;
                        phase_reg    <= 1'b0;
                        word_cnt_reg <= '0;
                    end
                end
                ST_RUN: begin
                    if (cmd.step) begin
                        phase_reg <= !phase_reg;
                        if (phase_reg) begin
                            byte_cnt_reg <= byte_cnt_reg + 2'd1;
                        end
                        if (cmd.out_load) begin
                            if (cmd.out_last) begin
                                state_reg    <= ST_IDLE;
                                word_cnt_reg <= '0;
                            end else begin
                                word_cnt_reg <= word_cnt_reg + WCW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // idle means no run in flight
    `XTKG_ASSERT_IMP(a_idle_clean, aclk, aresetn, s_tready, (word_cnt_reg == '0) && (byte_cnt_reg == 2'd0) && !phase_reg)
    // a finished word is never handed over while the output is blocked
    `XTKG_ASSERT_IMP(a_no_load_stalled, aclk, aresetn, cmd.out_load, !stat.stall)

endmodule

// File: rtl/xtkg_dp.sv
// datapath: xorshift128 state, table byte pick, word assembly, output register
`include "xorshift_table_key_generator_macros.svh"
module xtkg_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  xtkg_pkg::xtkg_cmd_t              cmd,
    output xtkg_pkg::xtkg_stat_t             stat,
    input  logic [xtkg_pkg::IN_DATA_W-1:0]   seed_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [xtkg_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import xtkg_pkg::*;

    logic [31:0]      gen_oldest_reg, gen_second_reg, gen_third_reg, gen_newest_reg;
    logic [31:0]      draw_val;
    logic [31:0]      entry_reg;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      base, shifted, merged;
    logic [4:0]       byte_sh;
    logic [7:0]       byte_val;
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_word_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_last_reg;

    assign draw_val   = gen_next(gen_oldest_reg, gen_newest_reg);
    assign stat.stall = out_valid_reg && !m_tready;

    // byte select and word assembly
    always_comb begin
        byte_sh  = {draw_val[31:30], 3'b000};
        shifted  = entry_reg >> byte_sh;
        byte_val = shifted[7:0];
        if (cmd.first_byte) begin
            base = cmd.word2 ? WORD2_START : '0;
        end else begin
            base = word_reg;
        end
        merged    = base | {24'b0, byte_val};
        word_next = cmd.last_byte ? merged : (merged << 8);
    end

    // generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_oldest_reg <= '0;
            gen_second_reg <= '0;
            gen_third_reg  <= '0;
            gen_newest_reg <= '0;
        end else if (cmd.seed_load) begin
            gen_oldest_reg <= seed_data[SEED_W-1:0];
            gen_second_reg <= seed_data[2*SEED_W-1:SEED_W];
            gen_third_reg  <= seed_data[3*SEED_W-1:2*SEED_W];
            gen_newest_reg <= seed_data[4*SEED_W-1:3*SEED_W];
        end else if (cmd.step) begin
            gen_oldest_reg <= gen_second_reg;
            gen_second_reg <= gen_third_reg;
            gen_third_reg  <= gen_newest_reg;
            gen_newest_reg <= draw_val;
        end
    end

    // table entry and partial word
    always_ff @(posedge aclk) begin
        if (cmd.step && !cmd.pick) begin
            entry_reg <= pick_word(draw_val[31:26]);
        end
        if (cmd.step && cmd.pick) begin
            word_reg <= word_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_word_reg  <= word_next;
            out_index_reg <= cmd.out_index;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-KEY_W-IDX_W){1'b0}}, out_index_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    // generator only moves on a draw or a seed load
    `XTKG_ASSERT_NXT(a_gen_hold, aclk, aresetn, !cmd.step && !cmd.seed_load, $stable(gen_newest_reg) && $stable(gen_oldest_reg))
    // a loaded word is offered next cycle
    `XTKG_ASSERT_NXT(a_load_shows, aclk, aresetn, cmd.out_load, out_valid_reg)

endmodule

// File: rtl/xorshift_table_key_generator.sv
// Each key word is built from four table bytes, two draws per byte, one draw per cycle
// on the single xorshift128 unit while the output is not stalled; a new input word is
// taken only once the last key word of the current one has been loaded for output.
// A stalled output holds the generator; the last word waits in the output register.
// Reset (aresetn low, synchronous) clears the generator state to zero and idles.
// top level: xorshift128 table-driven key generator
module xorshift_table_key_generator #(
    parameter int KEY_WORDS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // seed_first, seed_second, seed_third, seed_fourth
    input  logic [xtkg_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // key_word, word_index, zero fill
    output logic [xtkg_pkg::OUT_DATA_W-1:0]  m_tdata,
    // last_word
    output logic                             m_tlast
);
    import xtkg_pkg::*;

    xtkg_cmd_t  cmd;
    xtkg_stat_t stat;

    // sequencing
    xtkg_ctrl #(
        .KEY_WORDS (KEY_WORDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    // generator and key assembly
    xtkg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .seed_data (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: tb/sv/xorshift_table_key_generator_test.sv
// self-checking stream testbench for the xorshift table key generator
module xorshift_table_key_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_WORDS = 4;
    localparam logic [31:0] KEY2_START = 32'h82A28C10;

    // fixed pick table, 64 words
    localparam logic [31:0] PICK_ROM [64] = '{
        32'h39B399D2, 32'hFAE40B38, 32'h851BC213, 32'h8CB4E3D9,
        32'h7ED1C46A, 32'hE8050462, 32'hD8D24F76, 32'hB52886FC,
        32'h67890BF0, 32'hF5329CB0, 32'hD597FB28, 32'h2B8EE0EA,
        32'h47574C51, 32'h0F7569D9, 32'hCF1163AE, 32'hE4A153BF,
        32'hD1FAE468, 32'hD4C64738, 32'h360106F5, 32'hDD7EB113,
        32'hC296F3E2, 32'h2C58F258, 32'h79B554E1, 32'h85DF9D06,
        32'hAA307330, 32'h01410F69, 32'hB2F2C573, 32'h82B93EB1,
        32'hF351A11C, 32'h63098693, 32'h885B5DA5, 32'h8872A8ED,
        32'hACD9CB13, 32'hED7FBCAD, 32'hE6A41EC2, 32'h5F44E79F,
        32'h8346F5B5, 32'h389FE6ED, 32'h507124B5, 32'hE9B23EAA,
        32'h577113F0, 32'hA95ED917, 32'h2F62D158, 32'h47843F86,
        32'hC65637D0, 32'h2F272052, 32'hBA4A4CC4, 32'hB5F146F6,
        32'h501B87A7, 32'h51FC3A93, 32'h6EDE3F02, 32'h3D265728,
        32'h9B809440, 32'h75B89229, 32'hF6A280CC, 32'h8537FA68,
        32'h5B5ED19A, 32'h6FC05BB6, 32'hF4EF5261, 32'hAA1B7D4F,
        32'hFCB26110, 32'h00AD3D74, 32'hC0E73A4B, 32'hF132E7C7
    };

    localparam logic CMD_CONTINUE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    typedef struct {
        logic        cmd;
        logic [31:0] seed [4];
        logic        drain;
    } key_request_t;

    typedef struct {
        logic [31:0] key_word;
        logic [1:0]  word_index;
        logic        last_word;
    } key_word_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // seed_first, seed_second, seed_third, seed_fourth
    logic [xtkg_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // cmd
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // key_word, word_index, zero fill
    logic [xtkg_pkg::OUT_DATA_W-1:0] m_tdata;
    // last_word
    logic                            m_tlast;

    key_request_t requests [$];
    key_word_t    key_words_due [$];
    int           requests_offered = 0;
    int           requests_taken = 0;
    int           mismatches = 0;
    logic         quiet_stretch;

    // generator copy: x oldest .. w newest
    logic [31:0] gen_x = '0, gen_y = '0, gen_z = '0, gen_w = '0;

    xorshift_table_key_generator #(
        .KEY_WORDS(KEY_WORDS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // no random idling on either side in this window
    assign quiet_stretch = (requests_taken >= 250) && (requests_taken < 320);

    // one xorshift128 step on the local copy
    function automatic logic [31:0] xs_draw();
        logic [31:0] t;
        t = gen_x ^ (gen_x << 11);
        gen_x = gen_y;
        gen_y = gen_z;
        gen_z = gen_w;
        gen_w = gen_w ^ (gen_w >> 19) ^ t ^ (t >> 8);
        return gen_w;
    endfunction

    // two draws: table entry, then byte lane
    function automatic logic [31:0] next_key_byte();
        logic [31:0] entry;
        logic [4:0]  lane;
        entry = PICK_ROM[xs_draw() >> 26];
        lane = 5'((xs_draw() >> 27) & 32'h18);
        return (entry >> lane) & 32'hFF;
    endfunction

    // reseed if asked and queue up the key words this request yields
    function automatic void derive_key(input logic cmd, input logic [127:0] seeds);
        key_word_t   kw;
        logic [31:0] word;
        if (cmd == CMD_RESEED) begin
            {gen_w, gen_z, gen_y, gen_x} = seeds;
        end
        for (int i = 0; i < KEY_WORDS; i++) begin
            word = (i == 2) ? KEY2_START : 32'h0;
            for (int b = 0; b < 3; b++) begin
                word = (next_key_byte() | word) << 8;
            end
            word |= next_key_byte();
            kw.key_word = word;
            kw.word_index = 2'(i);
            kw.last_word = (i == KEY_WORDS - 1);
            key_words_due.push_back(kw);
        end
    endfunction

    function automatic void add_request(input logic cmd, input logic [31:0] s0,
                                        input logic [31:0] s1, input logic [31:0] s2,
                                        input logic [31:0] s3, input logic drain);
        key_request_t req;
        req.cmd = cmd;
        req.seed[0] = s0;
        req.seed[1] = s1;
        req.seed[2] = s2;
        req.seed[3] = s3;
        req.drain = drain;
        requests.push_back(req);
    endfunction

    // request driver, changes at the falling edge
    always @(negedge aclk) begin : drive_requests
        key_request_t req;
        if (aresetn && (!s_tvalid || requests_taken == requests_offered)) begin
            if (requests.size() != 0
                    && (!requests[0].drain || key_words_due.size() == 0)
                    && (quiet_stretch || $urandom_range(99) >= 23)) begin
                req = requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= req.cmd;
                s_tdata <= {req.seed[3], req.seed[2], req.seed[1], req.seed[0]};
                requests_offered++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin : drive_ready
        int   hold_left;
        logic hold_done;
        if (hold_done !== 1'b1 && requests_taken >= 120) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_stretch || ($urandom_range(99) >= 23);
        end
    end

    // input side: predict on every accepted word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            derive_key(s_tuser[0], s_tdata);
            requests_taken++;
        end
    end

    // output side: compare against the oldest expected key word
    always @(posedge aclk) begin : check_key_words
        key_word_t kw;
        if (aresetn && m_tvalid && m_tready) begin
            if (key_words_due.size() == 0) begin
                $display("%0t: unexpected key word: expected none, got %h idx %0d last %b",
                         $time, m_tdata[31:0], m_tdata[33:32], m_tlast);
                mismatches++;
            end else begin
                kw = key_words_due.pop_front();
                if (m_tdata[31:0] !== kw.key_word) begin
                    $display("%0t: key_word mismatch: expected %h, got %h",
                             $time, kw.key_word, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[33:32] !== kw.word_index) begin
                    $display("%0t: word_index mismatch: expected %0d, got %0d",
                             $time, kw.word_index, m_tdata[33:32]);
                    mismatches++;
                end
                if (m_tlast !== kw.last_word) begin
                    $display("%0t: last_word mismatch: expected %b, got %b",
                             $time, kw.last_word, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic        cmd;
        logic [31:0] s [4];
        logic        zero_seed;
        // all-zero reset state, seeds ignored on continue
        add_request(CMD_CONTINUE, '0, '0, '0, '0, 1'b0);
        add_request(CMD_CONTINUE, '1, '1, '1, '1, 1'b0);
        // all-zero seed loaded explicitly
        add_request(CMD_RESEED, '0, '0, '0, '0, 1'b0);
        add_request(CMD_RESEED, '1, '1, '1, '1, 1'b0);
        add_request(CMD_CONTINUE, '0, '0, '0, '0, 1'b0);
        // one seed word at its maximum, others zero
        add_request(CMD_RESEED, '1, '0, '0, '0, 1'b0);
        add_request(CMD_RESEED, '0, '1, '0, '0, 1'b0);
        add_request(CMD_RESEED, '0, '0, '1, '0, 1'b0);
        add_request(CMD_RESEED, '0, '0, '0, '1, 1'b1);
        add_request(CMD_RESEED, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 1'b0);
        add_request(CMD_CONTINUE, 32'h12345678, '0, '1, 32'h5A5A5A5A, 1'b0);
        add_request(CMD_RESEED, 32'h1, 32'h1, 32'h1, 32'h1, 1'b0);
        add_request(CMD_RESEED, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                    32'h55555555, 1'b0);
        add_request(CMD_CONTINUE, '1, '0, '1, '0, 1'b0);
        add_request(CMD_CONTINUE, '0, '0, '0, '0, 1'b1);
        // random part: mostly continues, a third reseeds, now and then a zero seed
        for (int n = 0; n < 465; n++) begin
            cmd = ($urandom_range(2) == 0) ? CMD_RESEED : CMD_CONTINUE;
            zero_seed = ($urandom_range(39) == 0);
            for (int k = 0; k < 4; k++) begin
                s[k] = zero_seed ? 32'h0 : $urandom();
            end
            add_request(cmd, s[0], s[1], s[2], s[3], (n % 150) == 149);
        end

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (requests.size() != 0 || requests_taken != requests_offered
               || key_words_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
